// ----- hw/rtl/msp_pkg.sv -----
package msp_pkg;

  localparam int unsigned CoordFieldW = 12;
  localparam int unsigned SpanW       = 12;
  localparam int unsigned TargetW     = 9;
  localparam int unsigned SlotW       = 8;
  localparam int unsigned CountOutW   = 9;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 12;

  localparam logic [CfgIdxW-1:0] CFG_SPAN   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_TARGET = 2'd1;

  localparam logic [SpanW-1:0]   SpanReset   = 12'd16;
  localparam logic [TargetW-1:0] TargetReset = 9'd64;

  typedef struct packed {
    logic                   cmd;
    logic [CoordFieldW-1:0] cand_x;
    logic [CoordFieldW-1:0] cand_y;
  } item_t;

  typedef struct packed {
    logic                 accepted;
    logic [SlotW-1:0]     slot_index;
    logic [CountOutW-1:0] accepted_count;
    logic                 run_done;
  } result_t;

  typedef enum logic {
    OP_OFFER,
    OP_RESTART
  } op_kind_e;

  typedef struct packed {
    op_kind_e               kind;
    logic [CoordFieldW-1:0] x;
    logic [CoordFieldW-1:0] y;
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } back_state_e;

endpackage

// ----- hw/rtl/msp_front.sv -----
module msp_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  msp_pkg::item_t item_i,
  input  logic           q_full_i,
  output logic           q_push_o,
  output msp_pkg::op_t   q_op_o
);

  logic         valid_q, valid_d;
  msp_pkg::op_t op_q;
  logic         take;

  assign busy     = valid_q && q_full_i;
  assign take     = start && !busy;
  assign q_push_o = valid_q && !q_full_i;
  assign q_op_o   = op_q;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (q_push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q.kind <= item_i.cmd ? msp_pkg::OP_RESTART : msp_pkg::OP_OFFER;
      op_q.x    <= item_i.cand_x;
      op_q.y    <= item_i.cand_y;
    end
  end

endmodule

// ----- hw/rtl/msp_queue.sv -----
module msp_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  msp_pkg::op_t op_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         empty_o,
  output msp_pkg::op_t op_o
);

  msp_pkg::op_t slots_q [2];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   fill_q;

  assign full_o  = (fill_q == 2'd2);
  assign empty_o = (fill_q == 2'd0);
  assign op_o    = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 2'd1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

// ----- hw/rtl/msp_back.sv -----
module msp_back #(
  parameter int unsigned MAX_POINTS = 256,
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_empty_i,
  input  msp_pkg::op_t                 q_op_i,
  output logic                         q_pop_o,
  input  logic [msp_pkg::SpanW-1:0]    span_i,
  input  logic [msp_pkg::TargetW-1:0]  target_i,
  output logic                         res_valid_o,
  output msp_pkg::result_t             res_o
);

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned TW = (CW > msp_pkg::TargetW) ? CW : msp_pkg::TargetW;
  localparam int unsigned DW = (COORD_BITS > msp_pkg::SpanW) ? COORD_BITS : msp_pkg::SpanW;

  logic [COORD_BITS-1:0] mem_x [MAX_POINTS];
  logic [COORD_BITS-1:0] mem_y [MAX_POINTS];

  msp_pkg::back_state_e  state_q, state_d;
  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic                  rd_vld_q, rd_vld_d;
  logic [COORD_BITS-1:0] cx_q, cy_q;
  logic [COORD_BITS-1:0] rdx_q, rdy_q;
  logic                  res_valid_q, res_valid_d;
  msp_pkg::result_t      res_q, res_d;

  logic [TW-1:0]         tgt_ext, eff_target;
  logic [CW-1:0]         count_inc;
  logic                  not_done;
  logic                  issuing;
  logic                  rd_en, wr_en, load_op;
  logic [COORD_BITS-1:0] dx, dy;
  logic                  hit;

  function automatic logic done_of(input logic [CW-1:0] c, input logic [TW-1:0] e);
    return TW'(c) >= e;
  endfunction

  assign tgt_ext    = TW'(target_i);
  assign eff_target = (tgt_ext > TW'(MAX_POINTS)) ? TW'(MAX_POINTS) : tgt_ext;
  assign count_inc  = count_q + 1'b1;
  assign not_done   = TW'(count_q) < eff_target;
  assign issuing    = (idx_q != count_q);

  assign dx  = (cx_q >= rdx_q) ? (cx_q - rdx_q) : (rdx_q - cx_q);
  assign dy  = (cy_q >= rdy_q) ? (cy_q - rdy_q) : (rdy_q - cy_q);
  assign hit = (DW'(dx) <= DW'(span_i)) && (DW'(dy) <= DW'(span_i));

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    rd_vld_d    = 1'b0;
    res_valid_d = 1'b0;
    res_d       = res_q;
    q_pop_o     = 1'b0;
    load_op     = 1'b0;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    case (state_q)
      msp_pkg::ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          if (q_op_i.kind == msp_pkg::OP_RESTART) begin
            count_d                = '0;
            res_valid_d            = 1'b1;
            res_d.accepted         = 1'b0;
            res_d.slot_index       = '0;
            res_d.accepted_count   = '0;
            res_d.run_done         = done_of('0, eff_target);
          end else if (!not_done) begin
            res_valid_d            = 1'b1;
            res_d.accepted         = 1'b0;
            res_d.slot_index       = '0;
            res_d.accepted_count   = msp_pkg::CountOutW'(count_q);
            res_d.run_done         = 1'b1;
          end else begin
            load_op = 1'b1;
            idx_d   = '0;
            state_d = msp_pkg::ST_SCAN;
          end
        end
      end
      msp_pkg::ST_SCAN: begin
        if (rd_vld_q && hit) begin
          res_valid_d          = 1'b1;
          res_d.accepted       = 1'b0;
          res_d.slot_index     = '0;
          res_d.accepted_count = msp_pkg::CountOutW'(count_q);
          res_d.run_done       = done_of(count_q, eff_target);
          state_d              = msp_pkg::ST_IDLE;
        end else if (issuing) begin
          rd_en    = 1'b1;
          rd_vld_d = 1'b1;
          idx_d    = idx_q + 1'b1;
        end else if (!rd_vld_q) begin
          wr_en                = 1'b1;
          count_d              = count_inc;
          res_valid_d          = 1'b1;
          res_d.accepted       = 1'b1;
          res_d.slot_index     = msp_pkg::SlotW'(count_q);
          res_d.accepted_count = msp_pkg::CountOutW'(count_inc);
          res_d.run_done       = done_of(count_inc, eff_target);
          state_d              = msp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = msp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= msp_pkg::ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      rd_vld_q    <= rd_vld_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (load_op) begin
      cx_q <= COORD_BITS'(q_op_i.x);
      cy_q <= COORD_BITS'(q_op_i.y);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_x[count_q[AW-1:0]] <= cx_q;
      mem_y[count_q[AW-1:0]] <= cy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdx_q <= mem_x[idx_q[AW-1:0]];
      rdy_q <= mem_y[idx_q[AW-1:0]];
    end
  end

endmodule

// ----- hw/rtl/min_separation_point_filter.sv -----
// A restart word, or a candidate once the run is done, passes the front register and a queue
// slot, and its result is registered in the back end; any other candidate first waits for a
// scan of the stored points in the back end, one entry per cycle.
// Restarts and candidates of a finished run go at one word per cycle while busy is low; any
// other candidate holds the back end until its scan of the stored points is over.
// Reset is asynchronous and active low; the receiver cannot stall, results last one cycle.
module min_separation_point_filter #(
  parameter int unsigned MAX_POINTS = 256,
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  msp_pkg::item_t                  item_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [msp_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [msp_pkg::CfgDataW-1:0]    cfg_wdata_i,
  output logic                            result_valid_o,
  output msp_pkg::result_t                result_o
);

  logic [msp_pkg::SpanW-1:0]   span_q;
  logic [msp_pkg::TargetW-1:0] target_q;
  logic                        q_full, q_push, q_empty, q_pop;
  msp_pkg::op_t                push_op, head_op;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_q   <= msp_pkg::SpanReset;
      target_q <= msp_pkg::TargetReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        msp_pkg::CFG_SPAN: begin
          span_q <= msp_pkg::SpanW'(cfg_wdata_i);
        end
        msp_pkg::CFG_TARGET: begin
          target_q <= msp_pkg::TargetW'(cfg_wdata_i);
        end
        default: begin
        end
      endcase
    end
  end

  msp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_op_o   (push_op)
  );

  msp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .op_i    (push_op),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .op_o    (head_op)
  );

  msp_back #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_op_i      (head_op),
    .q_pop_o     (q_pop),
    .span_i      (span_q),
    .target_i    (target_q),
    .res_valid_o (result_valid_o),
    .res_o       (result_o)
  );

endmodule

// ----- sim/tb_top.sv -----
module tb_top;
  import msp_pkg::*;

  localparam int unsigned MaxPoints  = 256;
  localparam int unsigned CoordMax   = (1 << CoordFieldW) - 1;
  localparam logic [CoordFieldW-1:0] CoordHi = CoordMax[CoordFieldW-1:0];
  localparam int unsigned RandWords  = 420;
  localparam int unsigned DrainWait  = MaxPoints + 40;
  localparam logic [CfgIdxW-1:0] CfgNoReg = 2'd3;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                start       = 1'b0;
  logic                busy;
  item_t               item_word   = '0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = CFG_SPAN;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                result_valid_o;
  result_t             result_word;

  min_separation_point_filter #(
    .MAX_POINTS(MaxPoints),
    .COORD_BITS(CoordFieldW)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item_word),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_word)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor state: a private copy of the registers and the point store.
  logic [SpanW-1:0]       span_q   = SpanReset;
  logic [TargetW-1:0]     target_q = TargetReset;
  logic [CoordFieldW-1:0] pt_x [MaxPoints];
  logic [CoordFieldW-1:0] pt_y [MaxPoints];
  int unsigned            n_stored = 0;

  item_t       pending_words[$];
  result_t     due_results[$];
  int          gen_x[$];
  int          gen_y[$];
  result_t     want;
  bit          steady_run = 1'b0;
  int unsigned gap_left   = 0;
  int unsigned gap_pick;
  int unsigned errors      = 0;
  int unsigned checked     = 0;
  int unsigned stored_seen = 0;
  int unsigned done_seen   = 0;
  int unsigned restarts    = 0;
  int unsigned cfg_writes  = 0;
  int unsigned phases      = 0;
  int unsigned random_words = 0;

  function automatic result_t filter_point(input item_t it);
    result_t     r;
    int unsigned goal;
    logic        hit;
    logic [CoordFieldW-1:0] dx;
    logic [CoordFieldW-1:0] dy;
    goal = (target_q > MaxPoints) ? MaxPoints : target_q;
    r    = '0;
    hit  = 1'b0;
    if (it.cmd == OP_RESTART) begin
      n_stored = 0;
    end else if (n_stored < goal) begin
      for (int unsigned i = 0; i < n_stored; i++) begin
        dx = (it.cand_x >= pt_x[i]) ? it.cand_x - pt_x[i] : pt_x[i] - it.cand_x;
        dy = (it.cand_y >= pt_y[i]) ? it.cand_y - pt_y[i] : pt_y[i] - it.cand_y;
        if (dx <= span_q && dy <= span_q) hit = 1'b1;
      end
      if (!hit) begin
        r.accepted   = 1'b1;
        r.slot_index = n_stored[SlotW-1:0];
        pt_x[n_stored] = it.cand_x;
        pt_y[n_stored] = it.cand_y;
        n_stored++;
      end
    end
    r.accepted_count = n_stored[CountOutW-1:0];
    r.run_done       = (n_stored >= goal);
    return r;
  endfunction

  function automatic int unsigned next_gap();
    int unsigned r;
    if (steady_run) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CoordFieldW-1:0] clamp_coord(input int v);
    if (v < 0) return '0;
    if (v > int'(CoordMax)) return CoordMax[CoordFieldW-1:0];
    return v[CoordFieldW-1:0];
  endfunction

  function automatic int near_offset(input int unsigned sp);
    int d;
    case ($urandom_range(0, 2))
      0: d = sp;
      1: d = sp + 1;
      default: d = $urandom_range(0, sp + 1);
    endcase
    return $urandom_range(0, 1) ? d : -d;
  endfunction

  // Driver: a word is taken when start is high and busy is low.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      due_results.push_back(filter_point(item_word));
      gap_pick = next_gap();
      if (gap_pick == 0 && pending_words.size() != 0) begin
        item_word <= pending_words.pop_front();
        start     <= 1'b1;
      end else begin
        start    <= 1'b0;
        gap_left <= gap_pick;
      end
    end else if (!start) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_words.size() != 0) begin
        item_word <= pending_words.pop_front();
        start     <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      checked++;
      if (due_results.size() == 0) begin
        $display("%0t: result word with nothing expected, expected none, got %0d/%0d/%0d/%0d",
                 $time, result_word.accepted, result_word.slot_index,
                 result_word.accepted_count, result_word.run_done);
        errors++;
      end else begin
        want = due_results.pop_front();
        check_field("accepted", 16'(want.accepted), 16'(result_word.accepted));
        check_field("slot_index", 16'(want.slot_index), 16'(result_word.slot_index));
        check_field("accepted_count", 16'(want.accepted_count),
                    16'(result_word.accepted_count));
        check_field("run_done", 16'(want.run_done), 16'(result_word.run_done));
        if (want.accepted) stored_seen++;
        if (want.run_done) done_seen++;
      end
    end
  end

  task automatic queue_word(input op_kind_e op, input logic [CoordFieldW-1:0] x,
                            input logic [CoordFieldW-1:0] y);
    item_t it;
    it.cmd    = op;
    it.cand_x = x;
    it.cand_y = y;
    pending_words.push_back(it);
    if (op == OP_RESTART) begin
      restarts++;
      gen_x.delete();
      gen_y.delete();
    end else begin
      gen_x.push_back(int'(x));
      gen_y.push_back(int'(y));
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_SPAN:   span_q   = data[SpanW-1:0];
      CFG_TARGET: target_q = data[TargetW-1:0];
      default: ;
    endcase
    cfg_writes++;
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    while (pending_words.size() != 0 || start || due_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_phase(input int unsigned n_words);
    int unsigned r;
    int unsigned k;
    logic [CoordFieldW-1:0] x;
    logic [CoordFieldW-1:0] y;
    for (int unsigned j = 0; j < n_words; j++) begin
      r = $urandom_range(0, 99);
      x = CoordFieldW'($urandom_range(0, CoordMax));
      y = CoordFieldW'($urandom_range(0, CoordMax));
      if (r < 6) begin
        queue_word(OP_RESTART, x, y);
      end else begin
        if (r < 45 && gen_x.size() != 0) begin
          k = $urandom_range(0, gen_x.size() - 1);
          x = clamp_coord(gen_x[k] + near_offset(32'(span_q)));
          y = clamp_coord(gen_y[k] + near_offset(32'(span_q)));
        end
        queue_word(OP_OFFER, x, y);
      end
      random_words++;
    end
  endtask

  initial begin
    int unsigned r;
    int unsigned tgt;
    logic [CfgDataW-1:0] span_w;
    bit big_done;
    big_done = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Register reset values: span 16, target 64.
    queue_word(OP_OFFER, 12'd0, 12'd0);
    queue_word(OP_OFFER, CoordHi, CoordHi);
    queue_word(OP_OFFER, 12'd16, 12'd16);
    queue_word(OP_OFFER, 12'd17, 12'd0);
    queue_word(OP_OFFER, CoordHi - 12'd16, CoordHi - 12'd17);
    queue_word(OP_OFFER, CoordHi - 12'd16, CoordHi - 12'd16);
    queue_word(OP_RESTART, CoordHi, CoordHi);
    queue_word(OP_OFFER, 12'd16, 12'd16);
    wait_idle();
    phases++;

    // Zero span still rejects an identical point; a small target ends the run.
    write_reg(CFG_SPAN, '0);
    write_reg(CFG_TARGET, 12'd2);
    queue_word(OP_OFFER, 12'd16, 12'd16);
    queue_word(OP_OFFER, 12'd17, 12'd16);
    queue_word(OP_OFFER, 12'd2048, 12'd2048);
    queue_word(OP_RESTART, 12'd0, 12'd0);
    wait_idle();
    phases++;

    // Widest span, target written with its unused upper bits set.
    write_reg(CFG_SPAN, CoordMax[CfgDataW-1:0]);
    write_reg(CFG_TARGET, 12'hE03);
    queue_word(OP_OFFER, 12'd2048, 12'd0);
    queue_word(OP_OFFER, 12'd0, CoordHi);
    queue_word(OP_OFFER, CoordHi, CoordHi);
    wait_idle();
    phases++;

    // A target of zero means the run is done from the start.
    write_reg(CFG_TARGET, '0);
    queue_word(OP_OFFER, 12'd0, 12'd0);
    queue_word(OP_RESTART, CoordHi, 12'd0);
    queue_word(OP_OFFER, CoordHi, 12'd0);
    wait_idle();
    phases++;

    write_reg(CfgNoReg, 12'hA5A);
    write_reg(CFG_TARGET, 12'd1);
    queue_word(OP_OFFER, 12'd100, 12'd100);
    queue_word(OP_OFFER, 12'd3000, 12'd3000);
    wait_idle();
    phases++;

    while (random_words < RandWords) begin
      wait_idle();
      steady_run = ($urandom_range(0, 3) == 0);
      if (!big_done && random_words >= 150) begin
        // Fill the whole store; the target saturates at the store depth.
        write_reg(CFG_SPAN, CfgDataW'($urandom_range(0, 3)));
        write_reg(CFG_TARGET, 12'h1FF);
        queue_word(OP_RESTART, CoordFieldW'($urandom_range(0, CoordMax)),
                   CoordFieldW'($urandom_range(0, CoordMax)));
        for (int unsigned j = 0; j < MaxPoints + 6; j++) begin
          queue_word(OP_OFFER, CoordFieldW'($urandom_range(0, CoordMax)),
                     CoordFieldW'($urandom_range(0, CoordMax)));
        end
        random_words += MaxPoints + 7;
        big_done = 1'b1;
      end else begin
        case ($urandom_range(0, 5))
          0: span_w = '0;
          1: span_w = CoordMax[CfgDataW-1:0];
          2: span_w = CfgDataW'($urandom_range(1, 8));
          3, 4: span_w = CfgDataW'($urandom_range(9, 200));
          default: span_w = CfgDataW'($urandom_range(201, 600));
        endcase
        case ($urandom_range(0, 7))
          0: tgt = 0;
          1: tgt = 1;
          2: tgt = MaxPoints;
          3: tgt = $urandom_range(MaxPoints + 1, 511);
          default: tgt = $urandom_range(2, 24);
        endcase
        tgt = tgt | ($urandom_range(0, 7) << TargetW);
        r = $urandom_range(0, 3);
        if (r != 1) write_reg(CFG_SPAN, span_w);
        if (r != 2) write_reg(CFG_TARGET, tgt[CfgDataW-1:0]);
        if (r == 3) write_reg(CfgNoReg, CfgDataW'($urandom_range(0, CoordMax)));
        random_phase($urandom_range(10, 40));
      end
      phases++;
    end

    wait_idle();
    repeat (DrainWait) @(posedge clk_i);
    $display("Checked %0d result words over %0d configuration phases with %0d register writes.",
             checked, phases, cfg_writes);
    $display("%0d points stored, %0d results flagged done, %0d restarts issued.",
             stored_seen, done_seen, restarts);
    if (errors == 0 && due_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (due_results.size() != 0) begin
        $display("%0t: %0d expected result words never arrived", $time, due_results.size());
      end
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("%0t: run timed out", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/msp_pkg.sv
hw/rtl/msp_front.sv
hw/rtl/msp_queue.sv
hw/rtl/msp_back.sv
hw/rtl/min_separation_point_filter.sv
sim/tb_top.sv
